### hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared clocked assertion forms for the expert selection histogram checks.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked on clk, ignored while rst_n is low.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked on clk, also checked while in reset.
`define ASSERT_CLK_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hw/rtl/ehist_pkg.sv
// ----------------------------------------------------------------------------
// ehist_pkg
// Operation codes, result kinds and port field widths of the histogram core.
// ----------------------------------------------------------------------------
package ehist_pkg;

  localparam int OP_W        = 2;
  localparam int LAYER_W     = 6;
  localparam int ID_W        = 9;
  localparam int OUT_CNT_W   = 48;
  localparam int SEEN_W      = 9;
  localparam int LSEEN_W     = 7;

  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 208;
  localparam int CFG_AW      = 3;
  localparam int CFG_DW      = 32;

  typedef enum logic [OP_W-1:0] {
    OP_RECORD   = 2'd0,
    OP_READ_CNT = 2'd1,
    OP_READ_TOT = 2'd2,
    OP_UNUSED   = 2'd3
  } op_t;

  localparam logic KIND_COUNT  = 1'b0;
  localparam logic KIND_TOTALS = 1'b1;

  // Register 0 (enable) decodes on the word index bit of paddr.
  localparam logic REG_ENABLE_IDX = 1'b0;

endpackage

### hw/rtl/ehist_ram.sv
// ----------------------------------------------------------------------------
// ehist_ram
// Simple dual-port RAM, one write port and one read port, registered read.
// ----------------------------------------------------------------------------
module ehist_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

### hw/rtl/expert_selection_histogram_core.sv
// ----------------------------------------------------------------------------
// expert_selection_histogram_core
// Per-layer histogram of expert routing choices, kept in two RAMs and
// updated by read-modify-write.
// ----------------------------------------------------------------------------
//  channel | direction | handshake               | payload
//  in_     | input     | in_tvalid / in_tready   | tuser op, tdata layer/id/prefill
//  out_    | output    | out_tvalid / out_tready | tuser kind, tdata counts
//  cfg_    | input     | APB psel/penable/pready | enable register at 0x0
//
// Items are handled one at a time: the accept cycle issues the RAM reads, and the
// next cycle modifies and writes back, as the RAM read is registered.
// After reset a clearing pass over all NUM_LAYERS*NUM_EXPERTS entries (16384 by
// default) zeroes both RAMs; in_tready stays low meanwhile.
// A read result waits in the update cycle while the output register is full.
// ----------------------------------------------------------------------------
module expert_selection_histogram_core #(
  parameter int NUM_LAYERS  = 64,
  parameter int NUM_EXPERTS = 256,
  parameter int COUNT_BITS  = 48
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // Input stream
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // [5:0] layer, [14:6] expert_id, [15] is_prefill
  input  logic [ehist_pkg::IN_TDATA_W-1:0] in_tdata,
  // [1:0] op
  input  logic [ehist_pkg::OP_W-1:0]       in_tuser,
  // Result stream
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // [47:0] expert count, [95:48] slot total, [143:96] prefill count,
  // [191:144] decode count, [200:192] experts seen, [207:201] layers seen
  output logic [ehist_pkg::OUT_TDATA_W-1:0] out_tdata,
  // [0] result_kind
  output logic                             out_tuser,
  // Configuration
  input  logic                             cfg_psel,
  input  logic                             cfg_penable,
  input  logic                             cfg_pwrite,
  input  logic [ehist_pkg::CFG_AW-1:0]     cfg_paddr,
  input  logic [ehist_pkg::CFG_DW-1:0]     cfg_pwdata,
  output logic [ehist_pkg::CFG_DW-1:0]     cfg_prdata,
  output logic                             cfg_pready
);

  import ehist_pkg::*;

  localparam int EXP_DEPTH = NUM_LAYERS * NUM_EXPERTS;
  localparam int EXP_AW    = (EXP_DEPTH > 1) ? $clog2(EXP_DEPTH) : 1;
  localparam int EXP_CW    = EXP_AW + 1;
  localparam int LAY_AW    = (NUM_LAYERS > 1) ? $clog2(NUM_LAYERS) : 1;
  localparam int LAY_W     = 3 * COUNT_BITS + SEEN_W;
  localparam int CMP_W     = 11;

  localparam logic [EXP_AW-1:0]     CLR_LAST = EXP_AW'(EXP_DEPTH - 1);
  localparam logic [COUNT_BITS-1:0] CNT_MAX  = '1;

  typedef enum logic [2:0] {
    S_CLEAR = 3'b001,
    S_IDLE  = 3'b010,
    S_UPD   = 3'b100
  } state_t;

  state_t state_r, state_nxt;
  logic [EXP_AW-1:0] clr_idx_r, clr_idx_nxt;
  logic enable_r;
  logic [LSEEN_W-1:0] hl_r, hl_nxt;

  // Held item
  op_t               op_r;
  logic [LAYER_W-1:0] layer_r;
  logic [ID_W-1:0]   id_r;
  logic              prefill_r;

  logic                   out_valid_r, out_valid_nxt;
  logic [OUT_TDATA_W-1:0] out_data_r, out_data_nxt;
  logic                   out_kind_r, out_kind_nxt;

  // RAM ports
  logic [LAYER_W-1:0]    a_layer;
  logic [7:0]            a_eid;
  logic [EXP_AW-1:0]     exp_addr;
  logic                  exp_we;
  logic [EXP_AW-1:0]     exp_waddr;
  logic [COUNT_BITS-1:0] exp_wd, exp_q;
  logic [LAY_AW-1:0]     lay_addr;
  logic                  lay_we;
  logic [LAY_AW-1:0]     lay_waddr;
  logic [LAY_W-1:0]      lay_wd, lay_q;

  // Update datapath
  logic                  layer_ok, expert_ok, rec_go, rd_op, out_free, cfg_wr;
  logic [COUNT_BITS-1:0] tot_q, pre_q, dec_q, tot_n, pre_n, dec_n, exp_n;
  logic [SEEN_W-1:0]     dist_q, dist_n;
  logic [LSEEN_W-1:0]    layer_p1;
  logic [63:0]           exp_q64, tot_q64, pre_q64, dec_q64;
  logic [OUT_CNT_W-1:0]  o_cnt, o_tot, o_pre, o_dec;
  logic [SEEN_W-1:0]     o_dist;

  // Reads are issued from the input in the accept cycle, then from the held item.
  assign a_layer  = (state_r == S_IDLE) ? in_tdata[5:0] : layer_r;
  assign a_eid    = (state_r == S_IDLE) ? in_tdata[13:6] : id_r[7:0];
  assign exp_addr = EXP_AW'(EXP_AW'(a_layer) * EXP_AW'(NUM_EXPERTS)) + EXP_AW'(a_eid);
  assign lay_addr = LAY_AW'(a_layer);

  assign layer_ok  = CMP_W'(layer_r) < CMP_W'(NUM_LAYERS);
  assign expert_ok = !id_r[ID_W-1] && (CMP_W'(id_r[7:0]) < CMP_W'(NUM_EXPERTS));
  assign rec_go    = (state_r == S_UPD) && (op_r == OP_RECORD) && enable_r && layer_ok;
  assign rd_op     = (op_r == OP_READ_CNT) || (op_r == OP_READ_TOT);
  assign out_free  = !out_valid_r || out_tready;

  assign tot_q  = lay_q[COUNT_BITS-1:0];
  assign pre_q  = lay_q[2*COUNT_BITS-1:COUNT_BITS];
  assign dec_q  = lay_q[3*COUNT_BITS-1:2*COUNT_BITS];
  assign dist_q = lay_q[LAY_W-1:3*COUNT_BITS];

  assign exp_n  = (exp_q == CNT_MAX) ? exp_q : exp_q + COUNT_BITS'(1);
  assign tot_n  = (tot_q == CNT_MAX) ? tot_q : tot_q + COUNT_BITS'(1);
  assign pre_n  = (!prefill_r || pre_q == CNT_MAX) ? pre_q : pre_q + COUNT_BITS'(1);
  assign dec_n  = (prefill_r || dec_q == CNT_MAX) ? dec_q : dec_q + COUNT_BITS'(1);
  // A count leaving zero adds a distinct expert to the layer.
  assign dist_n = (expert_ok && exp_q == '0) ? dist_q + SEEN_W'(1) : dist_q;

  assign exp_we    = (state_r == S_CLEAR) || (rec_go && expert_ok);
  assign exp_waddr = (state_r == S_CLEAR) ? clr_idx_r : exp_addr;
  assign exp_wd    = (state_r == S_CLEAR) ? '0 : exp_n;
  assign lay_we    = (state_r == S_CLEAR) ? (EXP_CW'(clr_idx_r) < EXP_CW'(NUM_LAYERS))
                                          : rec_go;
  assign lay_waddr = (state_r == S_CLEAR) ? LAY_AW'(clr_idx_r) : lay_addr;
  assign lay_wd    = (state_r == S_CLEAR) ? '0 : {dist_n, dec_n, pre_n, tot_n};

  ehist_ram #(.WIDTH(COUNT_BITS), .DEPTH(EXP_DEPTH), .AW(EXP_AW)) u_exp_ram (
    .clk     (clk),
    .wr_en   (exp_we),
    .wr_addr (exp_waddr),
    .wr_data (exp_wd),
    .rd_addr (exp_addr),
    .rd_data (exp_q)
  );

  ehist_ram #(.WIDTH(LAY_W), .DEPTH(NUM_LAYERS), .AW(LAY_AW)) u_lay_ram (
    .clk     (clk),
    .wr_en   (lay_we),
    .wr_addr (lay_waddr),
    .wr_data (lay_wd),
    .rd_addr (lay_addr),
    .rd_data (lay_q)
  );

  // Results are reported at 48 bits whatever the counter width.
  assign exp_q64 = 64'(exp_q);
  assign tot_q64 = 64'(tot_q);
  assign pre_q64 = 64'(pre_q);
  assign dec_q64 = 64'(dec_q);
  assign o_cnt   = (layer_ok && expert_ok) ? exp_q64[OUT_CNT_W-1:0] : '0;
  assign o_tot   = layer_ok ? tot_q64[OUT_CNT_W-1:0] : '0;
  assign o_pre   = layer_ok ? pre_q64[OUT_CNT_W-1:0] : '0;
  assign o_dec   = layer_ok ? dec_q64[OUT_CNT_W-1:0] : '0;
  assign o_dist  = layer_ok ? dist_q : '0;

  assign layer_p1 = LSEEN_W'(layer_r) + LSEEN_W'(1);
  assign cfg_wr   = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    state_nxt     = state_r;
    clr_idx_nxt   = clr_idx_r;
    hl_nxt        = hl_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    out_kind_nxt  = out_kind_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      S_CLEAR: begin
        clr_idx_nxt = clr_idx_r + EXP_AW'(1);
        if (clr_idx_r == CLR_LAST) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_tvalid) begin
          state_nxt = S_UPD;
        end
      end
      S_UPD: begin
        if (rec_go && layer_p1 > hl_r) begin
          hl_nxt = layer_p1;
        end
        if (!rd_op || out_free) begin
          state_nxt = S_IDLE;
        end
        if (rd_op && out_free) begin
          out_valid_nxt = 1'b1;
          if (op_r == OP_READ_CNT) begin
            out_kind_nxt = KIND_COUNT;
            out_data_nxt = {LSEEN_W'(0), SEEN_W'(0), OUT_CNT_W'(0), OUT_CNT_W'(0),
                            OUT_CNT_W'(0), o_cnt};
          end else begin
            out_kind_nxt = KIND_TOTALS;
            out_data_nxt = {hl_r, o_dist, o_dec, o_pre, o_tot, OUT_CNT_W'(0)};
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_idx_r   <= '0;
      hl_r        <= '0;
      enable_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_idx_r   <= clr_idx_nxt;
      hl_r        <= hl_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr && cfg_paddr[2] == REG_ENABLE_IDX) begin
        enable_r <= cfg_pwdata[0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      op_r      <= op_t'(in_tuser);
      layer_r   <= in_tdata[5:0];
      id_r      <= in_tdata[14:6];
      prefill_r <= in_tdata[15];
    end
    out_data_r <= out_data_nxt;
    out_kind_r <= out_kind_nxt;
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_kind_r;
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == REG_ENABLE_IDX) ? CFG_DW'(enable_r) : '0;

endmodule

### hw/rtl/ehist_checker.sv
// ----------------------------------------------------------------------------
// ehist_checker
// Port-level checks of the histogram core, attached by bind.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ehist_checker #(
  parameter int NUM_LAYERS = 64
) (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_tvalid,
  input logic                              in_tready,
  input logic                              out_tvalid,
  input logic                              out_tready,
  input logic [ehist_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic                              out_tuser
);

  import ehist_pkg::*;

  // A held result must not change until it is taken.
  `ASSERT_CLK(a_out_hold, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser), "result changed while stalled")

  // Reset starts the clearing pass: nothing accepted, nothing shown.
  `ASSERT_CLK_RST(a_reset_clear, !rst_n |=> !in_tready && !out_tvalid, "block active right after reset")

  // One item at a time: the cycle after an accept is the update cycle.
  `ASSERT_CLK(a_one_item, in_tvalid && in_tready |=> !in_tready, "second item accepted during update")

  // A count result carries no layer totals.
  `ASSERT_CLK(a_count_fields, out_tvalid && out_tuser == KIND_COUNT |-> out_tdata[207:48] == '0, "count result has totals set")

  // A totals result carries no expert count and a bounded layer tally.
  `ASSERT_CLK(a_total_fields, out_tvalid && out_tuser == KIND_TOTALS |-> out_tdata[47:0] == '0 && out_tdata[207:201] <= NUM_LAYERS, "bad totals result")

endmodule

bind expert_selection_histogram_core ehist_checker #(.NUM_LAYERS(NUM_LAYERS)) u_ehist_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
